@@ hw/rtl/fisr_pkg.sv @@
// ----------------------------------------------------------------------------
// fisr_pkg
// shared types, constants and the round-and-pack helper for the fast
// reciprocal square root pipeline
// ----------------------------------------------------------------------------
package fisr_pkg;

  localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF   = 32'h3f000000;
  localparam logic [31:0] THREE_HALF = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN  = 32'h7fc00000;

  // register stages of the two arithmetic units
  localparam int MUL_LAT = 3;
  localparam int SUB_LAT = 4;

  // operand class flags carried next to the datapath
  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
  } special_t;

  // n: 24-bit significand with leading one at the top, then guard, then sticky
  // value = 1.f * 2^(e-127); handles gradual underflow and overflow to inf
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [9:0] e,
                                             input logic [25:0] n);
    logic [9:0]  sh;
    logic [51:0] wide;
    logic [25:0] s;
    logic        inc;
    logic [24:0] rm;
    logic [7:0]  base;
    logic [30:0] mag;
    if (e > 10'sd0) begin
      sh = 10'd0;
    end else begin
      sh = 10'(10'sd1 - e);
    end
    if (sh > 10'd27) begin
      sh = 10'd27;
    end
    wide = {n, 26'b0} >> sh;
    s    = {wide[51:27], wide[26] | (|wide[25:0])};
    inc  = s[1] & (s[0] | s[2]);
    rm   = {1'b0, s[25:2]} + 25'(inc);
    base = (e > 10'sd0) ? 8'(e - 10'sd1) : 8'd0;
    mag  = {base, 23'b0} + 31'(rm);
    if (e >= 10'sd255) begin
      round_pack = {sgn, 8'hff, 23'b0};
    end else begin
      round_pack = {sgn, mag};
    end
  endfunction

endpackage

@@ hw/rtl/fast_inverse_sqrt_float_top.sv @@
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float_top
// streaming fast reciprocal square root with one newton step
// ----------------------------------------------------------------------------
// usage
//   s_* carries one word per operand: raw single-precision bits of x
//   m_* carries one word per result: inv_root_bits (low half) and
//   root_bits = x * y (high half), both single precision
//   seed = 0x5f3759df - (x >> 1), then h = x*0.5, t = h*y*y, t = 1.5 - t,
//   y = y*t, root = x*y, each rounded to nearest even
// throughput
//   one word per cycle sustained while m_tready stays high, set by the
//   chain of five 3-stage multipliers and one 4-stage subtractor running
//   in lockstep
// reset
//   rst clears all valid bits, m_tvalid and the skid slot flag among them
// stall
//   while m_tready is low the pipeline keeps running until the skid slot
//   fills; then s_tready drops and every stage holds, nothing is lost
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_float_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [31:0] inv_root_bits, [63:32] root_bits
);

  localparam int XD   = 3 * fisr_pkg::MUL_LAT + fisr_pkg::SUB_LAT + fisr_pkg::MUL_LAT;
  localparam int YD   = 2 * fisr_pkg::MUL_LAT + fisr_pkg::SUB_LAT + fisr_pkg::MUL_LAT;
  localparam int DEPTH = XD + fisr_pkg::MUL_LAT;

  logic             adv;
  logic [DEPTH-1:0] v;
  logic [31:0]      x_d  [XD];
  logic [31:0]      y_d  [YD];
  logic [31:0]      y2_d [fisr_pkg::MUL_LAT];
  logic [31:0]      seed;
  logic [31:0]      h, t1, t2, t3, y2, r;
  logic             skid_v;
  logic [63:0]      skid_d;
  logic [63:0]      tail;

  // pipeline moves whenever the skid slot is free
  assign adv      = !skid_v;
  assign s_tready = adv;
  assign seed     = fisr_pkg::SEED_MAGIC - (s_tdata >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[DEPTH-2:0], s_tvalid};
    end
  end

  // operand delay lines keep x and y in step with the arithmetic
  always_ff @(posedge clk) begin
    if (adv) begin
      x_d[0]  <= s_tdata;
      y_d[0]  <= seed;
      y2_d[0] <= y2;
      for (int i = 1; i < XD; i++) x_d[i] <= x_d[i-1];
      for (int i = 1; i < YD; i++) y_d[i] <= y_d[i-1];
      for (int i = 1; i < fisr_pkg::MUL_LAT; i++) y2_d[i] <= y2_d[i-1];
    end
  end

  // h = x * 0.5
  fisr_fmul u_mul_h (.clk(clk), .en(adv), .a(s_tdata), .b(fisr_pkg::ONE_HALF), .y(h));
  // t = h * y
  fisr_fmul u_mul_t1 (.clk(clk), .en(adv), .a(h), .b(y_d[fisr_pkg::MUL_LAT-1]), .y(t1));
  // t = t * y
  fisr_fmul u_mul_t2 (.clk(clk), .en(adv), .a(t1),
                      .b(y_d[2*fisr_pkg::MUL_LAT-1]), .y(t2));
  // t = 1.5 - t
  fisr_fsub u_sub (.clk(clk), .en(adv), .a(fisr_pkg::THREE_HALF), .b(t2), .y(t3));
  // y = y * t
  fisr_fmul u_mul_y (.clk(clk), .en(adv), .a(y_d[YD-1]), .b(t3), .y(y2));
  // root = x * y
  fisr_fmul u_mul_r (.clk(clk), .en(adv), .a(x_d[XD-1]), .b(y2), .y(r));

  assign tail = {r, y2_d[fisr_pkg::MUL_LAT-1]};

  // output register with one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else if (skid_v) begin
      if (m_tready) begin
        m_tdata <= skid_d;
        skid_v  <= 1'b0;
      end
    end else if (v[DEPTH-1]) begin
      if (!m_tvalid || m_tready) begin
        m_tdata  <= tail;
        m_tvalid <= 1'b1;
      end else begin
        skid_d <= tail;
        skid_v <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/fisr_fmul.sv @@
// ----------------------------------------------------------------------------
// fisr_fmul
// three-stage single-precision multiplier, round to nearest even
// ----------------------------------------------------------------------------
module fisr_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic [7:0]  ea, eb, eae, ebe;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  fisr_pkg::special_t sp0;

  // stage 1: significand product
  logic [47:0]        s1_p;
  logic signed [9:0]  s1_e;
  logic               s1_sgn;
  fisr_pkg::special_t s1_sp;

  // stage 2: normalized
  logic [25:0]        s2_n;
  logic signed [9:0]  s2_e;
  logic               s2_sgn;
  fisr_pkg::special_t s2_sp;

  logic [5:0]  lz;
  logic        found;
  logic [47:0] pn;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    nan_a  = (ea == 8'hff) && (fa != 23'd0);
    nan_b  = (eb == 8'hff) && (fb != 23'd0);
    inf_a  = (ea == 8'hff) && (fa == 23'd0);
    inf_b  = (eb == 8'hff) && (fb == 23'd0);
    zero_a = (ea == 8'd0) && (fa == 23'd0);
    zero_b = (eb == 8'd0) && (fb == 23'd0);
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    sp0.nan  = nan_a | nan_b | (inf_a & zero_b) | (inf_b & zero_a);
    sp0.inf  = inf_a | inf_b;
    sp0.zero = zero_a | zero_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_p   <= {|ea, fa} * {|eb, fb};
      s1_e   <= $signed({2'b0, eae}) + $signed({2'b0, ebe}) - 10'sd126;
      s1_sgn <= a[31] ^ b[31];
      s1_sp  <= sp0;
    end
  end

  // leading zero search
  always_comb begin
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && s1_p[i]) begin
        found = 1'b1;
        lz    = 6'(47 - i);
      end
    end
    pn = s1_p << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n   <= {pn[47:23], |pn[22:0]};
      s2_e   <= s1_e - $signed({4'b0, lz});
      s2_sgn <= s1_sgn;
      s2_sp  <= s1_sp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2_sp.nan) begin
        y <= fisr_pkg::CANON_NAN;
      end else if (s2_sp.inf) begin
        y <= {s2_sgn, 8'hff, 23'b0};
      end else if (s2_sp.zero) begin
        y <= {s2_sgn, 31'b0};
      end else begin
        y <= fisr_pkg::round_pack(s2_sgn, s2_e, s2_n);
      end
    end
  end

endmodule

@@ hw/rtl/fisr_fsub.sv @@
// ----------------------------------------------------------------------------
// fisr_fsub
// four-stage single-precision subtractor y = a - b, round to nearest even
// ----------------------------------------------------------------------------
module fisr_fsub (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);

  logic        sa, sb;
  logic [7:0]  ea, eb, eae, ebe;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, a_big;
  fisr_pkg::special_t sp0;

  // stage 1: ordered operands
  logic [23:0]        s1_mb, s1_ms;
  logic [7:0]         s1_eb, s1_d;
  logic               s1_sgn, s1_sub, s1_zs, s1_is;
  fisr_pkg::special_t s1_sp;

  // stage 2: aligned sum
  logic [27:0]        s2_sum;
  logic [7:0]         s2_eb;
  logic               s2_sgn, s2_zs, s2_is;
  fisr_pkg::special_t s2_sp;

  // stage 3: normalized
  logic [25:0]        s3_n;
  logic signed [9:0]  s3_e;
  logic               s3_sgn, s3_zres, s3_zs, s3_is;
  fisr_pkg::special_t s3_sp;

  logic [7:0]  dc;
  logic [53:0] wide;
  logic [26:0] al;
  logic [4:0]  lz;
  logic        found;
  logic [27:0] sn;

  always_comb begin
    sa = a[31];
    sb = ~b[31];
    ea = a[30:23];
    eb = b[30:23];
    fa = a[22:0];
    fb = b[22:0];
    nan_a = (ea == 8'hff) && (fa != 23'd0);
    nan_b = (eb == 8'hff) && (fb != 23'd0);
    inf_a = (ea == 8'hff) && (fa == 23'd0);
    inf_b = (eb == 8'hff) && (fb == 23'd0);
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    a_big = (a[30:0] >= b[30:0]);
    sp0.nan  = nan_a | nan_b | (inf_a & inf_b & (sa != sb));
    sp0.inf  = inf_a | inf_b;
    sp0.zero = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mb  <= a_big ? {|ea, fa} : {|eb, fb};
      s1_ms  <= a_big ? {|eb, fb} : {|ea, fa};
      s1_eb  <= a_big ? eae : ebe;
      s1_d   <= a_big ? (eae - ebe) : (ebe - eae);
      s1_sgn <= a_big ? sa : sb;
      s1_sub <= sa ^ sb;
      s1_zs  <= sa & sb;
      s1_is  <= inf_a ? sa : sb;
      s1_sp  <= sp0;
    end
  end

  // alignment with sticky
  always_comb begin
    dc   = (s1_d > 8'd27) ? 8'd27 : s1_d;
    wide = {s1_ms, 3'b0, 27'b0} >> dc;
    al   = {wide[53:28], wide[27] | (|wide[26:0])};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sum <= s1_sub ? ({1'b0, s1_mb, 3'b0} - {1'b0, al})
                       : ({1'b0, s1_mb, 3'b0} + {1'b0, al});
      s2_eb  <= s1_eb;
      s2_sgn <= s1_sgn;
      s2_zs  <= s1_zs;
      s2_is  <= s1_is;
      s2_sp  <= s1_sp;
    end
  end

  always_comb begin
    lz    = 5'd0;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && s2_sum[i]) begin
        found = 1'b1;
        lz    = 5'(27 - i);
      end
    end
    sn = s2_sum << lz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n    <= {sn[27:4], sn[3], |sn[2:0]};
      s3_e    <= $signed({2'b0, s2_eb}) + 10'sd1 - $signed({5'b0, lz});
      s3_sgn  <= s2_sgn;
      s3_zres <= (s2_sum == 28'd0);
      s3_zs   <= s2_zs;
      s3_is   <= s2_is;
      s3_sp   <= s2_sp;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_sp.nan) begin
        y <= fisr_pkg::CANON_NAN;
      end else if (s3_sp.inf) begin
        y <= {s3_is, 8'hff, 23'b0};
      end else if (s3_zres) begin
        y <= {s3_zs, 31'b0};
      end else begin
        y <= fisr_pkg::round_pack(s3_sgn, s3_e, s3_n);
      end
    end
  end

endmodule

@@ hw/rtl/fisr_checker.sv @@
// ----------------------------------------------------------------------------
// fisr_checker
// port-level checks for the fast reciprocal square root block
// ----------------------------------------------------------------------------
module fisr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // a stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  // a stalled word keeps its bits
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // any nan on the reciprocal output is the canonical one
  a_nan_inv: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[30:23] == 8'hff) && (m_tdata[22:0] != 23'd0)
    |-> m_tdata[31:0] == fisr_pkg::CANON_NAN)
    else $error("non-canonical nan on inv_root_bits");

  // any nan on the root output is the canonical one
  a_nan_root: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[62:55] == 8'hff) && (m_tdata[54:32] != 23'd0)
    |-> m_tdata[63:32] == fisr_pkg::CANON_NAN)
    else $error("non-canonical nan on root_bits");

endmodule

bind fast_inverse_sqrt_float_top fisr_checker u_fisr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/fast_inverse_sqrt_float_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fast_inverse_sqrt_float_top_tb
// self-checking bench for the streaming reciprocal square root block: a
// directed table, then random operands. A bit-exact single-precision model
// predicts untyped rows' words; random idles appear on both stream sides.
// ----------------------------------------------------------------------------
module fast_inverse_sqrt_float_top_tb;

  localparam int N_RANDOM = 800;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] inv_root;
    logic [31:0] root;
  } root_pair_t;

  // one directed row: operand, and an expected pair only where it is obvious
  typedef struct {
    logic [31:0] operand;
    bit          typed;
    root_pair_t  want;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // [31:0] value_bits
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;    // [31:0] inv_root_bits, [63:32] root_bits

  root_pair_t  pending_roots[$];
  int          n_errors;
  int          idle_cycles;
  bit          feed_done;
  bit          no_idle;    // long stretch with both sides always busy
  dir_row_t    dir_rows[$];

  fast_inverse_sqrt_float_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // bit-exact single-precision arithmetic, round to nearest even
  // ------------------------------------------------------------------------

  // value is sgn * m * 2^e2, m nonzero; handles subnormals and overflow
  function automatic logic [31:0] sp_round(input logic sgn, input int e2,
                                           input logic [127:0] m);
    int           p;
    int           sh;
    int           u;
    int           bexp;
    logic [127:0] q;
    logic         grd;
    logic         stk;
    p = 127;
    while (!m[p]) p--;
    sh = p - 23;
    if (-149 - e2 > sh) sh = -149 - e2;
    if (sh > 120) sh = 120;
    if (sh > 0) begin
      q   = m >> sh;
      grd = m[sh-1];
      stk = |(m & ((128'd1 << (sh - 1)) - 128'd1));
      if (grd && (stk || q[0])) q = q + 128'd1;
    end else begin
      q = m << (-sh);
    end
    u = e2 + sh;
    // rounding carried into a new binade
    if (q[24]) begin
      q = q >> 1;
      u++;
    end
    bexp = q[23] ? u + 150 : 0;
    if (bexp >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, bexp[7:0], q[22:0]};
  endfunction

  function automatic logic is_nan(input logic [31:0] w);
    return (w[30:23] == 8'hff) && (w[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input logic [31:0] w);
    return (w[30:23] == 8'hff) && (w[22:0] == 23'd0);
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] w);
    return (w[30:23] == 8'd0) ? {1'b0, w[22:0]} : {1'b1, w[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] w);
    return ((w[30:23] == 8'd0) ? 1 : int'(w[30:23])) - 150;
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return fisr_pkg::CANON_NAN;
      return {sgn, 8'hff, 23'd0};
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
    return sp_round(sgn, exp_of(a) + exp_of(b), 128'(sig_of(a)) * 128'(sig_of(b)));
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  tmp;
    logic [127:0] big;
    logic [127:0] lit;
    logic [127:0] sum;
    logic         sgn;
    int           d;
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : fisr_pkg::CANON_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (exp_of(b) > exp_of(a)) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    d   = exp_of(a) - exp_of(b);
    big = 128'(sig_of(a)) << 40;
    lit = 128'(sig_of(b)) << 40;
    // align the smaller operand, folding the lost bits into a sticky bit
    if (d >= 64) begin
      lit = 128'd1;
    end else if (d > 0) begin
      lit = (lit >> d) | 128'((lit & ((128'd1 << d) - 128'd1)) != 128'd0);
    end
    if (a[31] == b[31]) begin
      sum = big + lit;
      sgn = a[31];
    end else if (big >= lit) begin
      sum = big - lit;
      sgn = a[31];
    end else begin
      sum = lit - big;
      sgn = b[31];
    end
    if (sum == 128'd0) return 32'd0;
    return sp_round(sgn, exp_of(a) - 40, sum);
  endfunction

  // seed, one newton step, then the root as x * y
  function automatic root_pair_t predict_roots(input logic [31:0] x);
    logic [31:0] y;
    logic [31:0] h;
    logic [31:0] t;
    root_pair_t  res;
    y = fisr_pkg::SEED_MAGIC - (x >> 1);
    h = sp_mul(x, fisr_pkg::ONE_HALF);
    t = sp_mul(h, y);
    t = sp_mul(t, y);
    t = sp_add(fisr_pkg::THREE_HALF, {~t[31], t[30:0]});
    y = sp_mul(y, t);
    res.inv_root = y;
    res.root     = sp_mul(x, y);
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // operand generator: a mix of classes so every path is exercised
  // ------------------------------------------------------------------------
  function automatic logic [31:0] random_operand();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return $urandom();
    if (pick < 70) return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom())};
    if (pick < 80) return {1'($urandom()), 8'd0, 23'($urandom())};
    if (pick < 88) return {1'($urandom()), 8'hff, 23'($urandom_range(0, 3) == 0 ?
                                                     0 : $urandom())};
    if (pick < 94) return {1'($urandom()), 31'd0};
    return {1'($urandom()), 8'($urandom_range(0, 1) ? 8'hfe : 8'h01), 23'($urandom())};
  endfunction

  task automatic add_row(input logic [31:0] v, input bit typed = 1'b0,
                         input logic [31:0] inv = '0, input logic [31:0] rt = '0);
    dir_row_t row;
    row.operand       = v;
    row.typed         = typed;
    row.want.inv_root = inv;
    row.want.root     = rt;
    dir_rows.push_back(row);
  endtask

  // drive one operand word and wait for its acceptance
  task automatic send_word(input logic [31:0] v, input bit typed, input root_pair_t want);
    while (!no_idle && $urandom_range(0, 99) < 29) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    do @(posedge clk); while (!s_tready);
    pending_roots.push_back(typed ? want : predict_roots(v));
    @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    n_errors  = 0;
    feed_done = 1'b0;
    no_idle   = 1'b0;

    // quiet nan in, canonical nan out on both words
    add_row(32'h7fc00000, 1'b1, fisr_pkg::CANON_NAN, fisr_pkg::CANON_NAN);
    add_row(32'hffffffff, 1'b1, fisr_pkg::CANON_NAN, fisr_pkg::CANON_NAN);
    // +inf: newton step gives 1.5 - inf, so both words are -inf
    add_row(32'h7f800000, 1'b1, 32'hff800000, 32'hff800000);
    add_row(32'h00000000);    // +0
    add_row(32'h80000000);    // -0, sign bit shifts into the seed
    add_row(32'hff800000);    // -inf
    add_row(32'h3f800000);    // 1.0
    add_row(32'h40800000);    // 4.0
    add_row(32'h40490fdb);    // pi
    add_row(32'h7f7fffff);    // largest normal
    add_row(32'h00800000);    // smallest normal
    add_row(32'h007fffff);    // largest subnormal
    add_row(32'h00000001);    // smallest subnormal
    add_row(32'h80000001);
    add_row(32'hbf800000);    // -1.0
    add_row(32'h7fffffff);    // nan, all payload bits set
    add_row(32'h7f800001);    // signaling nan
    add_row(32'h5f3759df);
    add_row(32'haaaaaaaa);
    add_row(32'h55555555);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_word(dir_rows[i].operand, dir_rows[i].typed, dir_rows[i].want);
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 450);
      send_word(random_operand(), 1'b0, '0);
    end
    no_idle   = 1'b0;
    s_tvalid  = 1'b0;
    feed_done = 1'b1;
  end

  // result side backpressure
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = no_idle || ($urandom_range(0, 99) >= 29);
    end
  end

  // ------------------------------------------------------------------------
  // result checking against the oldest pending prediction
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    root_pair_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_roots.size() == 0) begin
        $error("result word with no prediction pending: %h", m_tdata);
        n_errors++;
      end else begin
        want = pending_roots.pop_front();
        if (m_tdata[31:0] !== want.inv_root) begin
          $error("inv_root_bits: expected %h, got %h", want.inv_root, m_tdata[31:0]);
          n_errors++;
        end
        if (m_tdata[63:32] !== want.root) begin
          $error("root_bits: expected %h, got %h", want.root, m_tdata[63:32]);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles in a row without any word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // end of run: drain, then keep watching for stray words before the verdict
  initial begin
    wait (feed_done);
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fisr_pkg.sv
hw/rtl/fisr_fmul.sv
hw/rtl/fisr_fsub.sv
hw/rtl/fast_inverse_sqrt_float_top.sv
hw/rtl/fisr_checker.sv
tb/fast_inverse_sqrt_float_top_tb.sv
